### hdl/assert_macros.svh
// Assertion shorthands for the RTL files; divisor_sum_top includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication that is checked only out of reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Clocked condition that must hold on every edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

### hdl/dvs_pkg.sv
package dvs_pkg;

  // Width of the divisor sum result.
  localparam int unsigned SUM_BITS = 36;

  // Control of the sum accumulator.
  typedef struct packed {
    logic clear;  // Restart the sum at one, since one divides every number.
    logic add;    // Add the presented addend to the sum.
  } acc_ctl_t;

endpackage

### hdl/dvs_div.sv
module dvs_div #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUMBER_BITS-1:0] dividend_i,
  input  logic [NUMBER_BITS-1:0] divisor_i,
  output logic                   done_o,
  output logic [NUMBER_BITS-1:0] quotient_o,
  output logic [NUMBER_BITS-1:0] remainder_o
);

  localparam int unsigned CntBits = $clog2(NUMBER_BITS + 1);

  logic [NUMBER_BITS-1:0] rem_q, rem_d;
  logic [NUMBER_BITS-1:0] quo_q, quo_d;
  logic [NUMBER_BITS-1:0] dvs_q;
  logic [CntBits-1:0]     cnt_q;
  logic                   run_q;
  logic                   done_q;
  logic [NUMBER_BITS:0]   partial;
  logic [NUMBER_BITS:0]   diff;
  logic                   fits;

  // One restoring step: bring down the next dividend bit and try the subtract.
  always_comb begin
    partial = {rem_q, quo_q[NUMBER_BITS-1]};
    diff    = partial - {1'b0, dvs_q};
    fits    = !diff[NUMBER_BITS];
    rem_d   = fits ? diff[NUMBER_BITS-1:0] : partial[NUMBER_BITS-1:0];
    quo_d   = {quo_q[NUMBER_BITS-2:0], fits};
  end

  // Control: one quotient bit per cycle, done pulses after the last bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntBits'(NUMBER_BITS);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient register shifts dividend bits out and quotient bits in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### hdl/dvs_acc.sv
module dvs_acc #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dvs_pkg::acc_ctl_t             ctl_i,
  input  logic [NUMBER_BITS-1:0]        addend_i,
  output logic [dvs_pkg::SUM_BITS-1:0]  sum_o
);

  import dvs_pkg::*;

  localparam int unsigned WideBits = (NUMBER_BITS > SUM_BITS) ? NUMBER_BITS : SUM_BITS;

  logic [WideBits-1:0] addend_wide;
  logic [SUM_BITS-1:0] addend_ext;
  logic [SUM_BITS-1:0] sum_q, sum_d;

  // Fit the addend to the sum width; the sum wraps past its top bit.
  always_comb begin
    addend_wide = WideBits'(addend_i);
    addend_ext  = addend_wide[SUM_BITS-1:0];
    sum_d       = sum_q;
    if (ctl_i.clear) begin
      sum_d = SUM_BITS'(1);
    end else if (ctl_i.add) begin
      sum_d = sum_q + addend_ext;
    end
  end

  // Running sum register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= SUM_BITS'(1);
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

### hdl/divisor_sum_top.sv
// Divisor sum by trial division. Raise start with a number while busy is low;
// the block then works on it alone and, when finished, shows the sum and the
// invalid flag for exactly one cycle with result_valid_o high. The receiver
// cannot stall, so capture the result in that cycle. Each trial divisor d runs
// through a bit-serial restoring divider that yields one quotient bit per
// cycle. A divisor d that divides adds d and, if different, its cofactor to
// the sum; trials end once the quotient drops below d, and a final step adds
// the number itself in the full-sum mode. Numbers 0 and 1 skip the divider.
// include_self (reset 1) selects the full sum including the number itself;
// write it only while busy is low.
`include "assert_macros.svh"

module divisor_sum_top #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [NUMBER_BITS-1:0]        number_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,
  output logic                          result_valid_o,
  output logic [dvs_pkg::SUM_BITS-1:0]  divisor_sum_o,
  output logic                          invalid_o
);

  import dvs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_ADD_D = 3'd3;
  localparam logic [2:0] ST_ADD_Q = 3'd4;
  localparam logic [2:0] ST_NEXT  = 3'd5;
  localparam logic [2:0] ST_ADD_N = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]             state_q, state_d;
  logic [NUMBER_BITS-1:0] num_q;
  logic [NUMBER_BITS-1:0] d_q;
  logic                   include_self_q;
  logic                   accept;
  logic                   num_small;
  logic                   div_start;
  logic                   div_done;
  logic [NUMBER_BITS-1:0] quot;
  logic [NUMBER_BITS-1:0] rem;
  acc_ctl_t               acc_ctl;
  logic [NUMBER_BITS-1:0] addend;
  logic [SUM_BITS-1:0]    acc_sum;
  logic                   res_valid_q;
  logic [SUM_BITS-1:0]    res_sum_q;
  logic                   res_invalid_q;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign num_small   = (num_q <= NUMBER_BITS'(1));

  // Mode register, written by a configuration transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      include_self_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      include_self_q <= cfg_data_i;
    end
  end

  // Sequencer over the trial divisors.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (number_i <= NUMBER_BITS'(1)) ? ST_FIN : ST_START;
        end
      end
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (quot < d_q) begin
            state_d = ST_ADD_N;
          end else if (rem == '0) begin
            state_d = ST_ADD_D;
          end else begin
            state_d = ST_NEXT;
          end
        end
      end
      ST_ADD_D: state_d = (quot != d_q) ? ST_ADD_Q : ST_NEXT;
      ST_ADD_Q: state_d = ST_NEXT;
      ST_NEXT:  state_d = ST_START;
      ST_ADD_N: state_d = ST_FIN;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Number and trial divisor registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q <= number_i;
      d_q   <= NUMBER_BITS'(2);
    end else if (state_q == ST_NEXT) begin
      d_q <= d_q + 1'b1;
    end
  end

  assign div_start = (state_q == ST_START);

  dvs_div #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (num_q),
    .divisor_i   (d_q),
    .done_o      (div_done),
    .quotient_o  (quot),
    .remainder_o (rem)
  );

  // Pick what goes into the sum: the divisor, its cofactor, or the number itself.
  always_comb begin
    acc_ctl.clear = accept;
    acc_ctl.add   = 1'b0;
    addend        = num_q;
    case (state_q)
      ST_ADD_D: begin
        acc_ctl.add = 1'b1;
        addend      = d_q;
      end
      ST_ADD_Q: begin
        acc_ctl.add = 1'b1;
        addend      = quot;
      end
      ST_ADD_N: begin
        acc_ctl.add = include_self_q;
        addend      = num_q;
      end
      default: begin
        acc_ctl.add = 1'b0;
      end
    endcase
  end

  dvs_acc #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (acc_ctl),
    .addend_i (addend),
    .sum_o    (acc_sum)
  );

  // Result register, shown for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q   <= 1'b0;
      res_invalid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == ST_FIN);
      if (state_q == ST_FIN) begin
        res_invalid_q <= include_self_q && num_small;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN) begin
      res_sum_q <= (include_self_q && num_small) ? '0 : acc_sum;
    end
  end

  assign result_valid_o = res_valid_q;
  assign divisor_sum_o  = res_sum_q;
  assign invalid_o      = res_invalid_q;

  // Checks on the sequencer and the result.
  `ASSERT_IMPLY(a_strobe_from_fin, result_valid_o, $past(state_q) == ST_FIN,
                "result strobe without a finishing step")
  `ASSERT_IMPLY(a_busy_ends_with_result, $fell(busy), result_valid_o,
                "busy dropped without a result")
  `ASSERT_IMPLY(a_invalid_zero_sum, result_valid_o && invalid_o, divisor_sum_o == '0,
                "invalid result carries a nonzero sum")
  `ASSERT_ALWAYS(a_divisor_floor, (state_q == ST_IDLE) || (d_q >= NUMBER_BITS'(2)),
                 "trial divisor below two")

endmodule

### tb/sv/divisor_sum_checker.sv
`timescale 1ns / 100ps

// Watches the item, result and mode channels of the divisor sum block, works out
// the expected sum of every accepted number and compares each result with it.
module divisor_sum_checker #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic [NUMBER_BITS-1:0]       number_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic                         cfg_data_i,
  input  logic                         result_valid_o,
  input  logic [dvs_pkg::SUM_BITS-1:0] divisor_sum_o,
  input  logic                         invalid_o,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o
);

  import dvs_pkg::*;

  typedef struct packed {
    logic [SUM_BITS-1:0] total;
    logic                invalid;
  } sum_result_t;

  // Mirror of the mode register: 1 selects the full sum, 0 the proper sum.
  logic        include_self_q = 1'b1;
  sum_result_t expected_sums[$];
  int          fail_count = 0;
  int          checked = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  // Trial division up to the integer root; an exact root is counted once.
  function automatic sum_result_t predict_sum(input logic [NUMBER_BITS-1:0] number,
                                              input logic full);
    sum_result_t      res;
    longint unsigned  n;
    longint unsigned  d;
    longint unsigned  co;
    longint unsigned  acc;
    n           = 64'(number);
    res.invalid = 1'b0;
    if (n <= 1) begin
      // Zero and one have no valid full sum; the proper sum is just one.
      if (full) begin
        res.total   = '0;
        res.invalid = 1'b1;
      end else begin
        res.total = SUM_BITS'(1);
      end
    end else begin
      acc = 1;
      for (d = 2; d <= n / d; d++) begin
        if (n % d == 0) begin
          co  = n / d;
          acc = acc + d;
          if (co != d) begin
            acc = acc + co;
          end
        end
      end
      if (full) begin
        acc = acc + n;
      end
      res.total = SUM_BITS'(acc);
    end
    return res;
  endfunction

  // Values are sampled as they stood before each edge; counts leave by
  // nonblocking update so the stimulus side reads them free of races.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    sum_result_t want;
    if (!rst_ni) begin
      include_self_q = 1'b1;
      expected_sums.delete();
    end else begin
      // Result transfer: compare with the oldest outstanding number.
      if (result_valid_o) begin
        if (expected_sums.size() == 0) begin
          $error("result with no number outstanding: divisor_sum %0d, invalid %0d",
                 divisor_sum_o, invalid_o);
          fail_count++;
        end else begin
          want = expected_sums.pop_front();
          checked++;
          if (divisor_sum_o !== want.total) begin
            $error("divisor_sum: expected %0d, got %0d", want.total, divisor_sum_o);
            fail_count++;
          end
          if (invalid_o !== want.invalid) begin
            $error("invalid: expected %0d, got %0d", want.invalid, invalid_o);
            fail_count++;
          end
        end
      end
      // Item transfer uses the mode in force before any write at this edge.
      if (start && !busy) begin
        expected_sums = {expected_sums, predict_sum(number_i, include_self_q)};
      end
      if (cfg_valid_i && cfg_ready_o) begin
        include_self_q = cfg_data_i;
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_sums.size();
    checked_o    <= checked;
  end

endmodule

### tb/sv/divisor_sum_top_tb.sv
`timescale 1ns / 100ps

module divisor_sum_top_tb;

  localparam int unsigned NUMBER_BITS = 32;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic [NUMBER_BITS-1:0]       number_i = '0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_data_i = 1'b0;
  logic                         busy;
  logic                         cfg_ready_o;
  logic                         result_valid_o;
  logic [dvs_pkg::SUM_BITS-1:0] divisor_sum_o;
  logic                         invalid_o;

  int fail_count;
  int pending;
  int checked;
  int idle_pct = 0;
  int numbers_sent = 0;

  // Directed numbers: range ends, primes, perfect numbers, squares, and 12,
  // whose divisor 3 equals its rounded root without being an exact root.
  logic [NUMBER_BITS-1:0] full_numbers [14] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd28, 32'd36, 32'd49,
    32'd97, 32'h0000_5555, 32'h0001_0000, 32'hFFFF_FFFF
  };
  logic [NUMBER_BITS-1:0] proper_numbers [9] = '{
    32'd0, 32'd1, 32'd2, 32'd12, 32'd28, 32'd36, 32'd49, 32'd97, 32'h0000_AAAA
  };
  int phase_idle [4] = '{0, 73, 27, 0};

  always #5 clk_i = ~clk_i;

  divisor_sum_top #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .number_i      (number_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .divisor_sum_o (divisor_sum_o),
    .invalid_o     (invalid_o)
  );

  divisor_sum_checker #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .number_i      (number_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .divisor_sum_o (divisor_sum_o),
    .invalid_o     (invalid_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Random gap before an item, with noise on the number while start is low,
  // then hold start until the block takes the number.
  task automatic send_number(input logic [NUMBER_BITS-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      start    <= 1'b0;
      number_i <= NUMBER_BITS'($urandom);
      @(posedge clk_i);
    end
    start    <= 1'b1;
    number_i <= value;
    do @(posedge clk_i); while (busy);
    numbers_sent++;
  endtask

  // Wait until every sum has come back and the block is idle again.
  task automatic drain_sums();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic full);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= full;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly narrow numbers keep the trial division short; some zeros and ones,
  // some perfect squares, and a few wider numbers.
  function automatic logic [NUMBER_BITS-1:0] random_number();
    int          kind;
    int unsigned root;
    int unsigned bits;
    kind = $urandom_range(99);
    if (kind < 8) begin
      return NUMBER_BITS'($urandom_range(1));
    end
    if (kind < 20) begin
      root = $urandom_range(255, 2);
      return NUMBER_BITS'(root * root);
    end
    if (kind < 26) begin
      bits = $urandom_range(22, 15);
    end else begin
      bits = $urandom_range(14, 2);
    end
    return NUMBER_BITS'($urandom & ((64'd1 << bits) - 1));
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed numbers, first in the full-sum mode left by reset.
    foreach (full_numbers[i]) begin
      send_number(full_numbers[i]);
    end
    drain_sums();
    write_mode(1'b0);
    foreach (proper_numbers[i]) begin
      send_number(proper_numbers[i]);
    end
    drain_sums();

    // Random phases, each with a mode and sender gap rate set at its start.
    for (int phase = 0; phase < 4; phase++) begin
      write_mode((phase < 2) ? ~phase[0] : 1'($urandom_range(1)));
      idle_pct = phase_idle[phase];
      repeat (25) begin
        send_number(random_number());
      end
      drain_sums();
    end

    $display("Covered %0d numbers in full and proper mode: range ends, squares, primes,",
             numbers_sent);
    $display("random widths, sender gaps at 0, 27 and 73 percent; %0d sums checked.",
             checked);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run including the full-range number.
  initial begin
    #400_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
